@@ rtl/detection_box_unletterbox_filter_unit_defines.svh @@
// Assertion macros shared by the detection box unletterbox filter RTL.
// Needs a clock named clock and an active-high synchronous reset named reset in scope.
`ifndef DETECTION_BOX_UNLETTERBOX_FILTER_UNIT_DEFINES_SVH
`define DETECTION_BOX_UNLETTERBOX_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DBU_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define DBU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/dbu_pkg.sv @@
// Package for the detection box unletterbox filter: payload, config and queue types.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package dbu_pkg;

   localparam int MAX_IMAGE_SIDE = 4096;
   localparam int COORD_W        = $clog2(MAX_IMAGE_SIDE);
   localparam int SIDE_W         = COORD_W + 1;
   localparam int NUM_LANES      = 4;
   localparam int CORNER_W       = 16;
   localparam int FRAC_BITS      = 4;
   localparam int PAD_W          = 12;
   localparam int DIFF_W         = 18;
   localparam int MAG_W          = DIFF_W - 1;
   localparam int INV_W          = 20;
   localparam int PROD_W         = MAG_W + INV_W;
   localparam int SCALE_SHIFT    = 20;
   localparam int RND_W          = PROD_W + 1 - SCALE_SHIFT;
   localparam int SCORE_W        = 16;
   localparam int LABEL_W        = 8;
   localparam int CSR_DATA_W     = 20;
   localparam int CSR_INDEX_W    = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   // lane order inside the queue entry
   localparam int LANE_X1 = 0;
   localparam int LANE_Y1 = 1;
   localparam int LANE_X2 = 2;
   localparam int LANE_Y2 = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CONF_THRESHOLD = 3'd0,
      CSR_PAD_LEFT       = 3'd1,
      CSR_PAD_TOP        = 3'd2,
      CSR_INV_SCALE      = 3'd3,
      CSR_IMAGE_WIDTH    = 3'd4,
      CSR_IMAGE_HEIGHT   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [CORNER_W-1:0] corner_x1;
      logic signed [CORNER_W-1:0] corner_y1;
      logic signed [CORNER_W-1:0] corner_x2;
      logic signed [CORNER_W-1:0] corner_y2;
      logic [SCORE_W-1:0]         score;
      logic [LABEL_W-1:0]         label;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] box_left;
      logic [COORD_W-1:0] box_top;
      logic [COORD_W-1:0] box_width;
      logic [COORD_W-1:0] box_height;
      logic [SCORE_W-1:0] box_score;
      logic [LABEL_W-1:0] box_label;
   } rsp_type;

   typedef struct packed {
      logic [SCORE_W-1:0] conf_threshold;
      logic [PAD_W-1:0]   pad_left;
      logic [PAD_W-1:0]   pad_top;
      logic [INV_W-1:0]   inv_scale;
      logic [COORD_W-1:0] hi_x;
      logic [COORD_W-1:0] hi_y;
   } cfg_type;

   // magnitude and sign of (corner - 16 * pad) per lane
   typedef struct packed {
      logic [NUM_LANES-1:0][MAG_W-1:0] mag;
      logic [NUM_LANES-1:0]            neg;
      logic [SCORE_W-1:0]              score;
      logic [LABEL_W-1:0]              label;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic almost_full;
   } q_status_type;

   // largest pixel index for an image side; zero counts as one, capped at the max side
   function automatic logic [COORD_W-1:0] side_limit(input logic [SIDE_W-1:0] side);
      logic [COORD_W-1:0] hi;
      if (side == '0) begin
         hi = '0;
      end else if (side > SIDE_W'(MAX_IMAGE_SIDE)) begin
         hi = COORD_W'(MAX_IMAGE_SIDE - 1);
      end else begin
         hi = COORD_W'(side - SIDE_W'(1));
      end
      return hi;
   endfunction

endpackage

@@ rtl/dbu_front.sv @@
// Front end: takes a request, applies the confidence threshold and removes padding.
// Depends on dbu_pkg; feeds dbu_queue.
`timescale 1ns / 1ps

module dbu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  dbu_pkg::req_type   req_data,
   input  dbu_pkg::cfg_type   cfg,
   output logic               push,
   output dbu_pkg::entry_type push_entry
);
   import dbu_pkg::*;

   logic                            keep;
   logic signed [NUM_LANES-1:0][CORNER_W-1:0] corner;
   logic [NUM_LANES-1:0][PAD_W-1:0] pad;
   logic signed [DIFF_W-1:0]        diff [NUM_LANES];
   entry_type                       entry_in;
   entry_type                       entry_ff;
   logic                            valid_in;
   logic                            valid_ff;

   always_comb begin
      keep = req_data.score >= cfg.conf_threshold;
      corner[LANE_X1] = req_data.corner_x1;
      corner[LANE_Y1] = req_data.corner_y1;
      corner[LANE_X2] = req_data.corner_x2;
      corner[LANE_Y2] = req_data.corner_y2;
      pad[LANE_X1] = cfg.pad_left;
      pad[LANE_Y1] = cfg.pad_top;
      pad[LANE_X2] = cfg.pad_left;
      pad[LANE_Y2] = cfg.pad_top;
      for (int i = 0; i < NUM_LANES; i++) begin
         // a lane select is unsigned, so the sign is put back before extending
         diff[i] = DIFF_W'($signed(corner[i])) -
                   $signed({2'b00, pad[i], {FRAC_BITS{1'b0}}});
         entry_in.neg[i] = diff[i][DIFF_W-1];
         entry_in.mag[i] = diff[i][DIFF_W-1] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
      end
      entry_in.score = req_data.score;
      entry_in.label = req_data.label;
      valid_in = accept && keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (valid_in) begin
         entry_ff <= entry_in;
      end
   end

   assign push       = valid_ff;
   assign push_entry = entry_ff;

endmodule

@@ rtl/dbu_queue.sv @@
// Short request queue between front and back end.
// Depends on dbu_pkg and the assertion macro header.
`timescale 1ns / 1ps

module dbu_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dbu_pkg::entry_type    push_entry,
   input  logic                  pop,
   output dbu_pkg::entry_type    pop_entry,
   output dbu_pkg::q_status_type status
);
   import dbu_pkg::*;
   `include "detection_box_unletterbox_filter_unit_defines.svh"

   entry_type         store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry          = store_ff[rd_ptr_ff];
   assign status.not_empty   = count_ff != '0;
   // one slot kept back for the request sitting in the front register
   assign status.almost_full = count_ff >= QCNT_W'(QUEUE_DEPTH - 1);

   `DBU_ASSERT_IMPLY(a_no_overflow, push && !pop, count_ff < QCNT_W'(QUEUE_DEPTH), "queue overflow")
   `DBU_ASSERT_IMPLY(a_no_underflow, pop, count_ff != '0, "queue underflow")

endmodule

@@ rtl/dbu_back.sv @@
// Back end: scale, round, clamp, size check and result register.
// Depends on dbu_pkg and the assertion macro header; drains dbu_queue.
`timescale 1ns / 1ps

module dbu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  dbu_pkg::entry_type in_entry,
   input  dbu_pkg::cfg_type   cfg,
   output logic               rsp_strobe,
   output dbu_pkg::rsp_type   rsp_data
);
   import dbu_pkg::*;
   `include "detection_box_unletterbox_filter_unit_defines.svh"

   // stage 1: products
   logic                            s1_valid_ff;
   logic [NUM_LANES-1:0][PROD_W-1:0] prod_ff, prod_in;
   logic [NUM_LANES-1:0]            neg_ff;
   logic [SCORE_W-1:0]              s1_score_ff;
   logic [LABEL_W-1:0]              s1_label_ff;

   // stage 2: clamped pixels
   logic                            s2_valid_ff;
   logic [NUM_LANES-1:0][COORD_W-1:0] coord_ff, coord_in;
   logic [SCORE_W-1:0]              s2_score_ff;
   logic [LABEL_W-1:0]              s2_label_ff;
   logic [PROD_W:0]                 rnd_sum [NUM_LANES];
   logic [RND_W-1:0]                rnd [NUM_LANES];
   logic [COORD_W-1:0]              hi [NUM_LANES];

   // stage 3: size check and result
   logic signed [COORD_W:0]         width, height;
   logic                            keep;
   rsp_type                         rsp_ff, rsp_in;
   logic                            strobe_ff;
   logic                            rsp_size_ok;

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         prod_in[i] = PROD_W'(in_entry.mag[i]) * PROD_W'(cfg.inv_scale);
      end
   end

   always_comb begin
      hi[LANE_X1] = cfg.hi_x;
      hi[LANE_Y1] = cfg.hi_y;
      hi[LANE_X2] = cfg.hi_x;
      hi[LANE_Y2] = cfg.hi_y;
      for (int i = 0; i < NUM_LANES; i++) begin
         rnd_sum[i] = {1'b0, prod_ff[i]} + (PROD_W+1)'(1 << (SCALE_SHIFT - 1));
         rnd[i]     = rnd_sum[i][PROD_W:SCALE_SHIFT];
         // a negative offset rounds to zero or below and so clamps to zero
         if (neg_ff[i]) begin
            coord_in[i] = '0;
         end else if (rnd[i] > RND_W'(hi[i])) begin
            coord_in[i] = hi[i];
         end else begin
            coord_in[i] = rnd[i][COORD_W-1:0];
         end
      end
   end

   always_comb begin
      width  = $signed({1'b0, coord_ff[LANE_X2]}) - $signed({1'b0, coord_ff[LANE_X1]});
      height = $signed({1'b0, coord_ff[LANE_Y2]}) - $signed({1'b0, coord_ff[LANE_Y1]});
      // signed compare, so reversed corners drop
      keep   = (width > $signed((COORD_W+1)'(1))) && (height > $signed((COORD_W+1)'(1)));
      rsp_in.box_left   = coord_ff[LANE_X1];
      rsp_in.box_top    = coord_ff[LANE_Y1];
      rsp_in.box_width  = width[COORD_W-1:0];
      rsp_in.box_height = height[COORD_W-1:0];
      rsp_in.box_score  = s2_score_ff;
      rsp_in.box_label  = s2_label_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         strobe_ff   <= s2_valid_ff && keep;
      end
      if (in_valid) begin
         prod_ff     <= prod_in;
         neg_ff      <= in_entry.neg;
         s1_score_ff <= in_entry.score;
         s1_label_ff <= in_entry.label;
      end
      if (s1_valid_ff) begin
         coord_ff    <= coord_in;
         s2_score_ff <= s1_score_ff;
         s2_label_ff <= s1_label_ff;
      end
      if (s2_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_data    = rsp_ff;
   assign rsp_size_ok = (rsp_ff.box_width > COORD_W'(1)) && (rsp_ff.box_height > COORD_W'(1));

   `DBU_ASSERT_IMPLY(a_rsp_size, strobe_ff, rsp_size_ok, "result box too small")
   `DBU_ASSERT_IMPLY(a_rsp_source, strobe_ff, $past(s2_valid_ff), "result without request")
   `DBU_ASSERT_NEXT(a_stage_flow, s1_valid_ff, s2_valid_ff, "request lost between stages")

endmodule

@@ rtl/detection_box_unletterbox_filter_unit.sv @@
// Kept requests pass the front, queue, product, clamp and result registers; dropped
// requests give no strobe. Throughput: one request per cycle, set by the fully
// pipelined multiply stage; busy stays low as the back end drains the queue every cycle.
// Reset (synchronous, active high) empties the pipe and queue and reloads the registers
// with their defaults. The receiver cannot stall results.
`timescale 1ns / 1ps

module detection_box_unletterbox_filter_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  dbu_pkg::req_type                      req_data,
   output logic                                  rsp_strobe,
   output dbu_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_we,
   input  logic [dbu_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [dbu_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import dbu_pkg::*;

   logic [SCORE_W-1:0] conf_threshold_ff;
   logic [PAD_W-1:0]   pad_left_ff;
   logic [PAD_W-1:0]   pad_top_ff;
   logic [INV_W-1:0]   inv_scale_ff;
   logic [SIDE_W-1:0]  image_width_ff;
   logic [SIDE_W-1:0]  image_height_ff;
   cfg_type            cfg;
   logic               accept;
   logic               push;
   entry_type          push_entry;
   entry_type          pop_entry;
   q_status_type       q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_threshold_ff <= SCORE_W'(16384);
         pad_left_ff       <= '0;
         pad_top_ff        <= '0;
         inv_scale_ff      <= INV_W'(65536);
         image_width_ff    <= SIDE_W'(640);
         image_height_ff   <= SIDE_W'(640);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CONF_THRESHOLD: conf_threshold_ff <= csr_wdata[SCORE_W-1:0];
            CSR_PAD_LEFT:       pad_left_ff       <= csr_wdata[PAD_W-1:0];
            CSR_PAD_TOP:        pad_top_ff        <= csr_wdata[PAD_W-1:0];
            CSR_INV_SCALE:      inv_scale_ff      <= csr_wdata[INV_W-1:0];
            CSR_IMAGE_WIDTH:    image_width_ff    <= csr_wdata[SIDE_W-1:0];
            CSR_IMAGE_HEIGHT:   image_height_ff   <= csr_wdata[SIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.conf_threshold = conf_threshold_ff;
      cfg.pad_left       = pad_left_ff;
      cfg.pad_top        = pad_top_ff;
      cfg.inv_scale      = inv_scale_ff;
      cfg.hi_x           = side_limit(image_width_ff);
      cfg.hi_y           = side_limit(image_height_ff);
   end

   assign busy   = q_status.almost_full;
   assign accept = start && !busy;

   dbu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .cfg        (cfg),
      .push       (push),
      .push_entry (push_entry)
   );

   dbu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_status.not_empty),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   dbu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_status.not_empty),
      .in_entry   (pop_entry),
      .cfg        (cfg),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

@@ tb/dbu_result_checker.sv @@
// Result checker for the detection box unletterbox filter: watches the request, result
// and register ports, predicts each kept box and compares it with what comes out.
// Depends on dbu_pkg for the payload types and register indexes.
`timescale 1ns / 1ps

module dbu_result_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  dbu_pkg::req_type                req_data,
   input  logic                            rsp_strobe,
   input  dbu_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [dbu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dbu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              pending
);
   import dbu_pkg::*;

   // shadow copy of the register file
   logic [SCORE_W-1:0] min_score;
   logic [PAD_W-1:0]   pad_x;
   logic [PAD_W-1:0]   pad_y;
   logic [INV_W-1:0]   unscale;
   logic [SIDE_W-1:0]  img_w;
   logic [SIDE_W-1:0]  img_h;

   rsp_type expected_boxes[$];
   int      fails = 0;

   assign fail_count = fails;

   // largest pixel index for a side; zero acts as one, capped at the max side
   function automatic longint last_pixel(input logic [SIDE_W-1:0] side);
      longint s;
      s = longint'(side);
      if (s < 1) begin
         s = 1;
      end
      if (s > MAX_IMAGE_SIDE) begin
         s = MAX_IMAGE_SIDE;
      end
      return s - 1;
   endfunction

   // Q12.4 corner to clamped whole pixel, rounding half away from zero
   function automatic longint unwarp(input logic signed [CORNER_W-1:0] corner,
                                     input logic [PAD_W-1:0] pad, input longint hi);
      longint d;
      longint mag;
      longint pix;
      d   = longint'(corner) - 16 * longint'(pad);
      mag = (d < 0) ? -d : d;
      pix = (mag * longint'(unscale) + (longint'(1) << 19)) >>> 20;
      if (d < 0) begin
         pix = -pix;
      end
      if (pix < 0) begin
         pix = 0;
      end
      if (pix > hi) begin
         pix = hi;
      end
      return pix;
   endfunction

   function automatic bit predict_box(input req_type det, output rsp_type box);
      longint hx, hy, left, top, right, bottom, w, h;
      box = '0;
      if (det.score < min_score) begin
         return 1'b0;
      end
      hx     = last_pixel(img_w);
      hy     = last_pixel(img_h);
      left   = unwarp(det.corner_x1, pad_x, hx);
      top    = unwarp(det.corner_y1, pad_y, hy);
      right  = unwarp(det.corner_x2, pad_x, hx);
      bottom = unwarp(det.corner_y2, pad_y, hy);
      w = (right > left) ? right - left : 0;
      h = (bottom > top) ? bottom - top : 0;
      if (w <= 1 || h <= 1) begin
         return 1'b0;
      end
      box.box_left   = COORD_W'(left);
      box.box_top    = COORD_W'(top);
      box.box_width  = COORD_W'(w);
      box.box_height = COORD_W'(h);
      box.box_score  = det.score;
      box.box_label  = det.label;
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type box;
      if (reset) begin
         min_score = SCORE_W'(16384);
         pad_x     = '0;
         pad_y     = '0;
         unscale   = INV_W'(65536);
         img_w     = SIDE_W'(640);
         img_h     = SIDE_W'(640);
         expected_boxes.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_boxes.size() == 0) begin
               $error("result with nothing expected: left %0d top %0d label %0d",
                      rsp_data.box_left, rsp_data.box_top, rsp_data.box_label);
               fails++;
            end else begin
               want = expected_boxes.pop_front();
               check_field("box_left", want.box_left, rsp_data.box_left);
               check_field("box_top", want.box_top, rsp_data.box_top);
               check_field("box_width", want.box_width, rsp_data.box_width);
               check_field("box_height", want.box_height, rsp_data.box_height);
               check_field("box_score", want.box_score, rsp_data.box_score);
               check_field("box_label", want.box_label, rsp_data.box_label);
            end
         end
         if (start && !busy && predict_box(req_data, box)) begin
            expected_boxes.insert(expected_boxes.size(), box);
         end
         // indexes past the last register are dropped
         if (csr_we) begin
            case (csr_index)
               CSR_CONF_THRESHOLD: min_score = csr_wdata[SCORE_W-1:0];
               CSR_PAD_LEFT:       pad_x     = csr_wdata[PAD_W-1:0];
               CSR_PAD_TOP:        pad_y     = csr_wdata[PAD_W-1:0];
               CSR_INV_SCALE:      unscale   = csr_wdata[INV_W-1:0];
               CSR_IMAGE_WIDTH:    img_w     = csr_wdata[SIDE_W-1:0];
               CSR_IMAGE_HEIGHT:   img_h     = csr_wdata[SIDE_W-1:0];
               default: ;
            endcase
         end
      end
      pending = expected_boxes.size();
   end

endmodule

@@ tb/tb_detection_box_unletterbox_filter_unit.sv @@
// Top of the detection box unletterbox filter testbench: clock, reset, register set-up
// and detection stimulus; dbu_result_checker does the predicting and comparing.
// Depends on dbu_pkg, dbu_result_checker and the detection_box_unletterbox_filter_unit RTL.
`timescale 1ns / 1ps

module tb_detection_box_unletterbox_filter_unit;
   import dbu_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int PIPE_SETTLE = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   start      = 1'b0;
   logic                   busy;
   req_type                req_data   = '0;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int fail_count;
   int pending;
   int cycle_count = 0;

   // what the stimulus needs to know of the current settings
   int cur_thr   = 16384;
   int cur_pad_l = 0;
   int cur_pad_t = 0;

   detection_box_unletterbox_filter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   dbu_result_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic signed [CORNER_W-1:0] sat16(input int v);
      if (v > 32767) begin
         v = 32767;
      end
      if (v < -32768) begin
         v = -32768;
      end
      return CORNER_W'(v);
   endfunction

   function automatic req_type box_req(input int x1, input int y1, input int x2,
                                       input int y2, input int score, input int label);
      req_type r;
      r.corner_x1 = sat16(x1);
      r.corner_y1 = sat16(y1);
      r.corner_x2 = sat16(x2);
      r.corner_y2 = sat16(y2);
      r.score     = SCORE_W'(score);
      r.label     = LABEL_W'(label);
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance, start left high
   task automatic send_request(input req_type item);
      start    <= 1'b1;
      req_data <= item;
      do begin
         @(posedge clock);
      end while (busy);
      @(negedge clock);
   endtask

   task automatic pause(input int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // hold off until every kept box is out and dropped requests have left the pipe
   task automatic drain_pipe();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (PIPE_SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_all(input int thr, input int pl, input int pt, input int inv,
                          input int w, input int h);
      write_reg(CSR_CONF_THRESHOLD, thr);
      write_reg(CSR_PAD_LEFT, pl);
      write_reg(CSR_PAD_TOP, pt);
      write_reg(CSR_INV_SCALE, inv);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      cur_thr   = thr & 16'hFFFF;
      cur_pad_l = pl & 12'hFFF;
      cur_pad_t = pt & 12'hFFF;
   endtask

   initial begin
      req_type  item;
      int       x1, y1, x2, y2, score, phase, n, count;
      bit       steady;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed requests on reset settings: 640x640, no padding, unit scale
      send_request(box_req(160, 320, 1600, 3200, 16384, 255));      // score on threshold
      send_request(box_req(160, 320, 1600, 3200, 16383, 1));        // just below
      send_request(box_req(-32768, -32768, 32767, 32767, 65535, 0));
      send_request(box_req(32767, 32767, 32767, 32767, 65535, 2));
      send_request(box_req(-32768, -32768, -32768, -32768, 65535, 3));
      send_request(box_req(1600, 1600, 160, 160, 40000, 7));        // reversed corners
      send_request(box_req(160, 160, 176, 320, 40000, 8));          // width of one
      send_request(box_req(160, 160, 192, 320, 40000, 9));          // width of two
      send_request(box_req(168, 167, 1608, 1607, 50000, 170));      // halves round up
      send_request(box_req(0, 0, 0, 0, 0, 0));
      pause(3);
      send_request(box_req(-21846, 21845, 21845, 32767, 43690, 85));
      send_request(box_req(21845, -21846, 32767, 21845, 21845, 170));
      drain_pipe();

      // padding with a half-pixel step, so rounding away from zero shows on both sides
      set_all(0, 10, 10, 32768, 640, 480);
      send_request(box_req(152, 144, 1000, 9000, 0, 4));
      send_request(box_req(168, 200, 184, 9999, 100, 5));
      send_request(box_req(400, 184, 8000, 216, 65535, 6));

      for (phase = 0; phase < 12; phase++) begin
         drain_pipe();
         case (phase)
            0: set_all(16384, 0, 0, 65536, 640, 640);
            1: set_all(0, 0, 80, 1048575, 4096, 8191);
            2: set_all(65535, 4095, 4095, 1, 0, 1);
            3: set_all(30000, 140, 0, 98304, 1920, 1080);
            5: set_all(0, 0, 0, 0, 640, 480);        // zero scale drops everything
            6: set_all(1, 0, 200, 131072, 4097, 4097);
            7: set_all(0, 0, 0, 65536, 1, 2);
            9: set_all($urandom_range(0, 65535), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(1, 1048575),
                       $urandom_range(0, 8191), $urandom_range(0, 8191));
            default: begin
               set_all($urandom_range(0, 40000), $urandom_range(0, 320),
                       $urandom_range(0, 320), $urandom_range(16384, 262144),
                       $urandom_range(1, 4096), $urandom_range(1, 4096));
               if (phase == 8) begin
                  write_reg(CSR_SPARE_LO, $urandom);
                  write_reg(CSR_SPARE_HI, $urandom);
               end
            end
         endcase
         count  = (phase == 2 || phase == 5 || phase == 7) ? 30 : 140;
         steady = (phase == 3);

         for (n = 0; n < count; n++) begin
            if (!steady && $urandom_range(99) < 37) begin
               pause($urandom_range(1, 4));
            end
            if ($urandom_range(99) < 25) begin
               item.corner_x1 = CORNER_W'($urandom);
               item.corner_y1 = CORNER_W'($urandom);
               item.corner_x2 = CORNER_W'($urandom);
               item.corner_y2 = CORNER_W'($urandom);
               item.score     = SCORE_W'($urandom);
               item.label     = LABEL_W'($urandom);
            end else begin
               x1 = cur_pad_l * 16 + int'($urandom_range(0, 16 * 720)) - 240;
               y1 = cur_pad_t * 16 + int'($urandom_range(0, 16 * 720)) - 240;
               x2 = x1 + int'(($urandom_range(3) == 0) ? $urandom_range(0, 48)
                                                       : $urandom_range(0, 16 * 450));
               y2 = y1 + int'(($urandom_range(3) == 0) ? $urandom_range(0, 48)
                                                       : $urandom_range(0, 16 * 450));
               if ($urandom_range(19) == 0) begin
                  score = cur_thr;
               end else if (cur_thr == 0 || $urandom_range(9) < 8) begin
                  score = $urandom_range(cur_thr, 65535);
               end else begin
                  score = $urandom_range(0, cur_thr - 1);
               end
               item = box_req(x1, y1, x2, y2, score, $urandom_range(0, 255));
            end
            send_request(item);
         end
      end

      drain_pipe();
      if (fail_count == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/dbu_pkg.sv
rtl/dbu_front.sv
rtl/dbu_queue.sv
rtl/dbu_back.sv
rtl/detection_box_unletterbox_filter_unit.sv
tb/dbu_result_checker.sv
tb/tb_detection_box_unletterbox_filter_unit.sv
